// ===== sv/hsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsf_pkg
// Shared constants, configuration types and helpers of the 8-tap filter core.
// ----------------------------------------------------------------------------
package hsf_pkg;

	localparam int TAPS       = 8;
	localparam int WIN        = TAPS - 1;
	localparam int TAP_BITS   = 16;
	localparam int SHIFT_BITS = 7;
	localparam int ROUND_BIAS = 1 << (SHIFT_BITS - 1);
	localparam int MIN_BIT_DEPTH = 8;

	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 64;

	localparam logic [CFG_ADDR_BITS-1:0] REG_HTAPS_LO     = 3'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_HTAPS_HI     = 3'd1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_VTAPS_LO     = 3'd2;
	localparam logic [CFG_ADDR_BITS-1:0] REG_VTAPS_HI     = 3'd3;
	localparam logic [CFG_ADDR_BITS-1:0] REG_BIT_DEPTH    = 3'd4;
	localparam logic [CFG_ADDR_BITS-1:0] REG_FILTER_MODE  = 3'd5;
	localparam logic [CFG_ADDR_BITS-1:0] REG_BLOCK_WIDTH  = 3'd6;
	localparam logic [CFG_ADDR_BITS-1:0] REG_BLOCK_HEIGHT = 3'd7;

	localparam logic [1:0] MODE_HORIZ = 2'd0;
	localparam logic [1:0] MODE_VERT  = 2'd1;
	localparam logic [1:0] MODE_2D    = 2'd2;

	typedef logic [TAP_BITS-1:0] tap_t;
	typedef tap_t [TAPS-1:0] tap_set_t;

	typedef struct packed {
		logic [63:0] htaps_hi;
		logic [63:0] htaps_lo;
		logic [63:0] vtaps_hi;
		logic [63:0] vtaps_lo;
		logic [3:0]  bit_depth;
		logic [1:0]  filter_mode;
		logic [6:0]  block_width;
		logic [6:0]  block_height;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		htaps_hi: 64'd0,
		htaps_lo: 64'd0,
		vtaps_hi: 64'd0,
		vtaps_lo: 64'd0,
		bit_depth: 4'd8,
		filter_mode: MODE_2D,
		block_width: 7'd64,
		block_height: 7'd64
	};

	// remainder by seven: reciprocal estimate (73/512) then one correction
	function automatic logic [2:0] mod7(input logic [9:0] v);
		logic [16:0] prod;
		logic [7:0]  quot;
		logic [10:0] rem;
		prod = 17'(v) * 17'd73;
		quot = prod[16:9];
		rem = 11'(v) - 11'(quot) * 11'd7;
		if (rem >= 11'd7) begin
			rem = rem - 11'd7;
		end
		return rem[2:0];
	endfunction

endpackage

// ===== sv/hsf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word when the same entry is written at this edge
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/hsf_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsf_cfg_regs
// Configuration register file: taps, bit depth, mode and block size.
// ----------------------------------------------------------------------------
module hsf_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                write,
	input  logic [hsf_pkg::CFG_ADDR_BITS-1:0]   addr,
	input  logic [hsf_pkg::CFG_DATA_BITS-1:0]   data,
	output hsf_pkg::cfg_t                       cfg
);

	hsf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= hsf_pkg::CFG_RESET;
		end else if (write) begin
			case (addr)
				hsf_pkg::REG_HTAPS_LO:     cfg_q.htaps_lo <= data;
				hsf_pkg::REG_HTAPS_HI:     cfg_q.htaps_hi <= data;
				hsf_pkg::REG_VTAPS_LO:     cfg_q.vtaps_lo <= data;
				hsf_pkg::REG_VTAPS_HI:     cfg_q.vtaps_hi <= data;
				hsf_pkg::REG_BIT_DEPTH:    cfg_q.bit_depth <= data[3:0];
				hsf_pkg::REG_FILTER_MODE:  cfg_q.filter_mode <= data[1:0];
				hsf_pkg::REG_BLOCK_WIDTH:  cfg_q.block_width <= data[6:0];
				hsf_pkg::REG_BLOCK_HEIGHT: cfg_q.block_height <= data[6:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/hsf_fir8.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsf_fir8
// Three-stage 8-tap FIR: products, pair sums, then sum, round and clamp.
// ----------------------------------------------------------------------------
module hsf_fir8 #(
	parameter int PIXEL_BITS = 12
) (
	input  logic                  clk,
	input  logic [PIXEL_BITS-1:0] samples [hsf_pkg::TAPS],
	input  hsf_pkg::tap_set_t     taps,
	input  logic [PIXEL_BITS-1:0] max_value,
	output logic [PIXEL_BITS-1:0] result
);

	localparam int PW = PIXEL_BITS + hsf_pkg::TAP_BITS + 1;
	localparam int SW = PW + 1;
	localparam int AW = PW + 3;
	localparam int QW = AW - hsf_pkg::SHIFT_BITS;
	localparam int PAIRS = hsf_pkg::TAPS / 2;

	logic signed [PW-1:0] prod_s1 [hsf_pkg::TAPS];
	logic signed [SW-1:0] pair_s2 [PAIRS];
	logic signed [AW-1:0] acc;
	logic signed [QW-1:0] quot;
	logic signed [QW-1:0] max_ext;
	logic [PIXEL_BITS-1:0] clamped;

	always_ff @(posedge clk) begin
		for (int k = 0; k < hsf_pkg::TAPS; k++) begin
			prod_s1[k] <= $signed({1'b0, samples[k]}) * $signed(taps[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < PAIRS; j++) begin
			pair_s2[j] <= SW'(prod_s1[2*j]) + SW'(prod_s1[2*j+1]);
		end
	end

	always_comb begin
		acc = AW'(signed'(hsf_pkg::ROUND_BIAS));
		for (int j = 0; j < PAIRS; j++) begin
			acc = acc + AW'(pair_s2[j]);
		end
		// arithmetic shift gives the floor for negative sums
		quot = QW'(acc >>> hsf_pkg::SHIFT_BITS);
		max_ext = $signed(QW'(max_value));
		if (quot < 0) begin
			clamped = '0;
		end else if (quot > max_ext) begin
			clamped = max_value;
		end else begin
			clamped = quot[PIXEL_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		result <= clamped;
	end

endmodule

// ===== sv/hsf_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsf_out_fifo
// Small result queue between the filter pipeline and the output channel.
// ----------------------------------------------------------------------------
module hsf_out_fifo #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	assign valid = count_q != '0;
	assign data = entry_q[rd_ptr_q];

endmodule

// ===== sv/highbd_separable_8tap_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// highbd_separable_8tap_filter_core
// Horizontal, vertical or separable 2D 8-tap filter on a raster pixel stream.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  -------  --------------------  ---------------------------------------
//  in       in_valid / in_stall   pixel, block_start
//  out      out_valid / out_stall out_pixel, row_end, block_end
//  cfg      cfg_write             cfg_addr, cfg_data (no wait, no read-back)
//
//  one pixel per clock sustained while in_stall is low; each result passes
//  through the horizontal and vertical 3-stage FIR pipes and then the queue;
//  the line store is a read-modify-write RAM, one word per column holding
//  the last seven rows; back-to-back hits on one column are forwarded
//  reset clears counters, window, configuration and queue; no clearing pass
//  in_stall rises only when the queue plus in-flight pixels fill 8 places
// ----------------------------------------------------------------------------
module highbd_separable_8tap_filter_core #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int PIXEL_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [hsf_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [hsf_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [PIXEL_BITS-1:0]             pixel,
	input  logic                              block_start,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [PIXEL_BITS-1:0]             out_pixel,
	output logic                              row_end,
	output logic                              block_end
);

	localparam int PB = PIXEL_BITS;
	localparam int WIN = hsf_pkg::WIN;
	localparam int CW = $clog2(MAX_WIDTH + hsf_pkg::TAPS);
	localparam int RW = $clog2(MAX_HEIGHT + hsf_pkg::TAPS);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int PIPE_STAGES = 6;
	localparam int FIFO_DEPTH = PIPE_STAGES + 2;
	localparam int OW = $clog2(FIFO_DEPTH + 1);
	localparam int WORD_W = WIN * PB;

	typedef struct packed {
		logic          horiz;
		logic          vert;
		logic          emit;
		logic          wr;
		logic [XW-1:0] x;
		logic [2:0]    slot;
		logic          row_end;
		logic          block_end;
		logic [PB-1:0] val;
	} meta_t;

	hsf_pkg::cfg_t     cfg;
	hsf_pkg::tap_set_t htaps;
	hsf_pkg::tap_set_t vtaps;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [PB-1:0] win_q [WIN];

	logic          accept;
	logic          pop;
	logic          push;
	logic          drop;
	logic [OW-1:0] occ_q;

	logic          horiz;
	logic          vert;
	logic [CW-1:0] w_c;
	logic [RW-1:0] h_c;
	logic [4:0]    bd_c;
	logic [PB-1:0] max_value;
	logic [CW-1:0] rowlen;
	logic [RW-1:0] rows;
	logic [CW-1:0] c_raw;
	logic [RW-1:0] r_raw;
	logic [CW-1:0] c;
	logic [RW-1:0] r;
	logic [CW-1:0] x_full;
	logic          last_col;
	logic          last_row;
	logic          have;
	meta_t         meta_s0;

	logic  valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;

	logic [PB-1:0] hsamples [hsf_pkg::TAPS];
	logic [PB-1:0] vsamples [hsf_pkg::TAPS];
	logic [PB-1:0] hfir_res;
	logic [PB-1:0] vfir_res;
	logic [PB-1:0] val_s3;
	meta_t         meta_s3_out;

	logic [WORD_W-1:0] ram_rdata;
	logic [WORD_W-1:0] base_word;
	logic [WORD_W-1:0] new_word;
	logic              ram_we;
	logic              fwd_valid_q;
	logic [XW-1:0]     fwd_addr_q;
	logic [WORD_W-1:0] fwd_word_q;

	logic [PB-1:0]   res_s6;
	logic [PB+1:0]   fifo_wdata;
	logic [PB+1:0]   fifo_rdata;

	hsf_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.write  (cfg_write),
		.addr   (cfg_addr),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	assign htaps = {cfg.htaps_hi, cfg.htaps_lo};
	assign vtaps = {cfg.vtaps_hi, cfg.vtaps_lo};

	assign in_stall = occ_q >= OW'(FIFO_DEPTH);
	assign accept = in_valid && !in_stall;
	assign pop = out_valid && !out_stall;

	// position, clamps and window taps of the incoming pixel
	always_comb begin
		horiz = cfg.filter_mode != hsf_pkg::MODE_VERT;
		vert = cfg.filter_mode != hsf_pkg::MODE_HORIZ;

		if (cfg.block_width == '0) begin
			w_c = CW'(1);
		end else if (32'(cfg.block_width) > 32'(MAX_WIDTH)) begin
			w_c = CW'(MAX_WIDTH);
		end else begin
			w_c = CW'(cfg.block_width);
		end

		if (cfg.block_height == '0) begin
			h_c = RW'(1);
		end else if (32'(cfg.block_height) > 32'(MAX_HEIGHT)) begin
			h_c = RW'(MAX_HEIGHT);
		end else begin
			h_c = RW'(cfg.block_height);
		end

		if (32'(cfg.bit_depth) < 32'(hsf_pkg::MIN_BIT_DEPTH)) begin
			bd_c = 5'(hsf_pkg::MIN_BIT_DEPTH);
		end else if (32'(cfg.bit_depth) > 32'(PB)) begin
			bd_c = 5'(PB);
		end else begin
			bd_c = 5'(cfg.bit_depth);
		end
		max_value = {PB{1'b1}} >> (5'(PB) - bd_c);

		rowlen = w_c + (horiz ? CW'(WIN) : '0);
		rows = h_c + (vert ? RW'(WIN) : '0);

		c_raw = block_start ? '0 : col_q;
		r_raw = block_start ? '0 : row_q;
		c = (c_raw >= rowlen) ? rowlen - CW'(1) : c_raw;
		r = (r_raw >= rows) ? rows - RW'(1) : r_raw;

		last_col = c == rowlen - CW'(1);
		last_row = r == rows - RW'(1);
		have = !horiz || (c >= CW'(WIN));
		x_full = horiz ? c - CW'(WIN) : c;

		meta_s0.horiz = horiz;
		meta_s0.vert = vert;
		meta_s0.emit = have && (!vert || (r >= RW'(WIN)));
		meta_s0.wr = have && vert;
		meta_s0.x = x_full[XW-1:0];
		meta_s0.slot = hsf_pkg::mod7(10'(r));
		meta_s0.row_end = last_col;
		meta_s0.block_end = last_col && last_row;
		meta_s0.val = pixel;

		for (int k = 0; k < WIN; k++) begin
			hsamples[k] = win_q[k];
		end
		hsamples[WIN] = pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int k = 0; k < WIN; k++) begin
				win_q[k] <= '0;
			end
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : r + RW'(1);
			end else begin
				col_q <= c + CW'(1);
				row_q <= r;
			end
			if (horiz) begin
				for (int k = 0; k < WIN - 1; k++) begin
					win_q[k] <= win_q[k+1];
				end
				win_q[WIN-1] <= pixel;
			end
		end
	end

	hsf_fir8 #(.PIXEL_BITS(PB)) u_hfir (
		.clk       (clk),
		.samples   (hsamples),
		.taps      (htaps),
		.max_value (max_value),
		.result    (hfir_res)
	);

	// pipeline valids; sideband rides along with the FIR stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1 <= meta_s0;
		meta_s2 <= meta_s1;
		meta_s3 <= meta_s2;
		meta_s4 <= meta_s3_out;
		meta_s5 <= meta_s4;
		meta_s6 <= meta_s5;
	end

	// line store: column word read in s2, updated and written back in s3
	hsf_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WIDTH)) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (meta_s3.x),
		.wdata (new_word),
		.raddr (meta_s2.x),
		.rdata (ram_rdata)
	);

	always_comb begin
		logic [3:0] idx;
		val_s3 = meta_s3.horiz ? hfir_res : meta_s3.val;
		meta_s3_out = meta_s3;
		meta_s3_out.val = val_s3;

		// the read raced the previous write to the same column
		base_word = (fwd_valid_q && (fwd_addr_q == meta_s3.x)) ? fwd_word_q : ram_rdata;

		new_word = base_word;
		new_word[int'(meta_s3.slot) * PB +: PB] = val_s3;

		// oldest row first: slots rotate from this row's slot
		for (int k = 0; k < WIN; k++) begin
			idx = 4'(meta_s3.slot) + 4'(k);
			if (idx >= 4'(WIN)) begin
				idx = idx - 4'(WIN);
			end
			vsamples[k] = base_word[int'(idx) * PB +: PB];
		end
		vsamples[WIN] = val_s3;

		ram_we = valid_s3 && meta_s3.wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= meta_s3.x;
		fwd_word_q <= new_word;
	end

	hsf_fir8 #(.PIXEL_BITS(PB)) u_vfir (
		.clk       (clk),
		.samples   (vsamples),
		.taps      (vtaps),
		.max_value (max_value),
		.result    (vfir_res)
	);

	assign res_s6 = meta_s6.vert ? vfir_res : meta_s6.val;
	assign push = valid_s6 && meta_s6.emit;
	assign drop = valid_s6 && !meta_s6.emit;
	assign fifo_wdata = {meta_s6.row_end, meta_s6.block_end, res_s6};

	hsf_out_fifo #(.WIDTH(PB + 2), .DEPTH(FIFO_DEPTH)) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (fifo_wdata),
		.pop       (pop),
		.valid     (out_valid),
		.data      (fifo_rdata)
	);

	assign row_end = fifo_rdata[PB+1];
	assign block_end = fifo_rdata[PB];
	assign out_pixel = fifo_rdata[PB-1:0];

	// places taken by pixels in flight plus queued results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OW'(accept) - OW'(pop) - OW'(drop);
		end
	end

endmodule

// ===== sv/hsf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsf_checker
// Port-level checks of the filter core, bound to its top level.
// ----------------------------------------------------------------------------
module hsf_checker #(
	parameter int PIXEL_BITS = 12
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [PIXEL_BITS-1:0] out_pixel,
	input logic                  row_end,
	input logic                  block_end
);

	localparam int LATENCY = 7;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_pixel)
			&& $stable(row_end) && $stable(block_end))
	else $error("stalled output changed");

	// the last pixel of a block also closes its row
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && block_end |-> row_end)
	else $error("block_end without row_end");

	// input stall only when results are queued
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
	else $error("input stalled with empty output queue");

	// a result appearing on an empty queue came from a pixel taken earlier
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, LATENCY))
	else $error("result appeared without a matching input transaction");

endmodule

bind highbd_separable_8tap_filter_core hsf_checker #(.PIXEL_BITS(PIXEL_BITS)) u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_pixel (out_pixel),
	.row_end   (row_end),
	.block_end (block_end)
);
